// ----- rtl/core/lfu_pkg.sv -----
package lfu_pkg;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned ValW   = 32;
  localparam int unsigned CntW   = 32;
  localparam int unsigned LimitW = 5;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE,
    ST_DONE
  } state_e;

  // broadcast from the controller to every cell in the update cycle
  typedef struct packed {
    logic touch;
    logic evict;
    logic fill;
  } cell_cmd_t;

endpackage

// ----- rtl/core/lfu_cell.sv -----
module lfu_cell import lfu_pkg::*; #(
  parameter int unsigned IdxW = 4,
  parameter int unsigned RankW = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [KeyW-1:0]         key_i,
  input  logic [ValW-1:0]         val_i,
  input  logic [IdxW-1:0]         my_idx_i,
  input  cell_cmd_t               cmd_i,
  input  logic                    put_i,
  input  logic [IdxW-1:0]         sel_idx_i,
  input  logic [RankW-1:0]        sel_rank_i,
  input  logic [RankW-1:0]        top_rank_i,
  input  logic [RankW-1:0]        new_rank_i,
  // reduction chain in: best so far
  input  logic                    bv_i,
  input  logic [CntW-1:0]         bcnt_i,
  input  logic [RankW-1:0]        brank_i,
  input  logic [IdxW-1:0]         bidx_i,
  input  logic                    fv_i,
  input  logic [IdxW-1:0]         fidx_i,
  output logic                    bv_o,
  output logic [CntW-1:0]         bcnt_o,
  output logic [RankW-1:0]        brank_o,
  output logic [IdxW-1:0]         bidx_o,
  output logic                    fv_o,
  output logic [IdxW-1:0]         fidx_o,
  output logic                    match_o,
  output logic                    valid_o,
  output logic [ValW-1:0]         value_o,
  output logic [RankW-1:0]        rank_o
);

  logic             valid_q, valid_d;
  logic [KeyW-1:0]  key_q, key_d;
  logic [ValW-1:0]  val_q, val_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [RankW-1:0] rank_q, rank_d;
  logic             sel, better;
  logic             bv_q, bv_d;
  logic [CntW-1:0]  bcnt_q, bcnt_d;
  logic [RankW-1:0] brank_q, brank_d;
  logic [IdxW-1:0]  bidx_q, bidx_d;
  logic             fv_q, fv_d;
  logic [IdxW-1:0]  fidx_q, fidx_d;

  assign match_o = valid_q && (key_q == key_i);
  assign valid_o = valid_q;
  assign value_o = val_q;
  assign rank_o  = rank_q;
  assign sel     = (sel_idx_i == my_idx_i);

  // one chain stage per cycle
  assign better = valid_q && (!bv_i || (cnt_q < bcnt_i) ||
                  ((cnt_q == bcnt_i) && (rank_q < brank_i)));
  assign bv_d    = bv_i || valid_q;
  assign bcnt_d  = better ? cnt_q : bcnt_i;
  assign brank_d = better ? rank_q : brank_i;
  assign bidx_d  = better ? my_idx_i : bidx_i;
  // lowest free slot wins: chain runs from the top slot down
  assign fv_d    = fv_i || !valid_q;
  assign fidx_d  = !valid_q ? my_idx_i : fidx_i;

  assign bv_o    = bv_q;
  assign bcnt_o  = bcnt_q;
  assign brank_o = brank_q;
  assign bidx_o  = bidx_q;
  assign fv_o    = fv_q;
  assign fidx_o  = fidx_q;

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    val_d   = val_q;
    cnt_d   = cnt_q;
    rank_d  = rank_q;
    if (cmd_i.touch) begin
      if (sel) begin
        if (put_i) val_d = val_i;
        if (cnt_q != '1) cnt_d = cnt_q + 1'b1;
        rank_d = top_rank_i;
      end else if (valid_q && rank_q > sel_rank_i) begin
        rank_d = rank_q - 1'b1;
      end
    end else if (cmd_i.evict) begin
      if (sel) begin
        valid_d = 1'b0;
      end else if (valid_q && rank_q > sel_rank_i) begin
        rank_d = rank_q - 1'b1;
      end
    end else if (cmd_i.fill && sel) begin
      valid_d = 1'b1;
      key_d   = key_i;
      val_d   = val_i;
      cnt_d   = CntW'(1);
      rank_d  = new_rank_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      bv_q    <= 1'b0;
      bcnt_q  <= '0;
      brank_q <= '0;
      bidx_q  <= '0;
      fv_q    <= 1'b0;
      fidx_q  <= '0;
    end else begin
      valid_q <= valid_d;
      bv_q    <= bv_d;
      bcnt_q  <= bcnt_d;
      brank_q <= brank_d;
      bidx_q  <= bidx_d;
      fv_q    <= fv_d;
      fidx_q  <= fidx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    val_q  <= val_d;
    cnt_q  <= cnt_d;
    rank_q <= rank_d;
  end

endmodule

// ----- rtl/core/lfu_cache_table.sv -----
// lfu_cache_table: key-value store with least-frequently-used replacement,
// oldest entry evicted on equal counts.
// usage: drive opcode_i, lookup_key_i and store_value_i and pulse start_i
// while busy_o is low; the item is taken at that edge and busy_o rises.
// the result (read_value_o, hit_o) appears with done_o high for exactly one
// cycle; the receiver cannot stall it and must take it then.
// read_value_o is the stored value on a get hit, -1 on a get miss, 0 on put.
// the min-count and free-slot search moves one cell per cycle along the row.
// each item steps through the search, update and done states and then the
// result; busy_o is low in the result cycle, so the next item can be taken
// at the edge that ends it.
// a put of a new key into a full store evicts and then fills, staying in the
// update state for both steps.
// entry_limit_we_i / entry_limit_i write the capacity (clamped to ENTRIES);
// write only while idle. zero capacity ignores puts.
// reset: all entries invalid, fill zero, capacity 16.
module lfu_cache_table import lfu_pkg::*; #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic                     opcode_i,
  input  logic signed [KeyW-1:0]   lookup_key_i,
  input  logic signed [ValW-1:0]   store_value_i,
  input  logic                     entry_limit_we_i,
  input  logic [LimitW-1:0]        entry_limit_i,
  output logic                     done_o,
  output logic signed [ValW-1:0]   read_value_o,
  output logic                     hit_o
);

  localparam int unsigned IdxW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned RankW = IdxW;
  localparam int unsigned FillW = $clog2(ENTRIES + 1);
  localparam int unsigned CapW  = (FillW > LimitW) ? FillW : LimitW;

  state_e state_q, state_d;
  logic              op_q;
  logic [KeyW-1:0]   key_q;
  logic [ValW-1:0]   val_q;
  logic [LimitW-1:0] limit_q;
  logic [FillW-1:0]  fill_q, fill_d;
  logic              hit_q;
  logic [IdxW-1:0]   hidx_q;
  logic [RankW-1:0]  hrank_q;
  logic [IdxW-1:0]   eidx_q;
  logic [RankW-1:0]  erank_q;
  logic [IdxW-1:0]   fidx_q;
  logic              fv_q;
  logic [IdxW-1:0]   free_idx;
  logic [IdxW-1:0]   scan_q, scan_d;
  logic              scan_last;
  logic              evicted_q, evicted_d;
  logic [ValW-1:0]   rd_q, rd_d;
  logic              rhit_q;
  logic              done_q;
  cell_cmd_t         cmd;
  logic [IdxW-1:0]   sel_idx;
  logic [RankW-1:0]  sel_rank;
  logic [CapW-1:0]   cap;
  logic              need_evict;

  logic [ENTRIES:0]            bv, fv;
  logic [ENTRIES:0][CntW-1:0]  bcnt;
  logic [ENTRIES:0][RankW-1:0] brank;
  logic [ENTRIES:0][IdxW-1:0]  bidx, fidx;
  logic [ENTRIES-1:0]          match, valid;
  logic [ENTRIES-1:0][ValW-1:0]  value;
  logic [ENTRIES-1:0][RankW-1:0] rank;
  logic              any_hit;
  logic [IdxW-1:0]   m_idx;
  logic [ValW-1:0]   m_val;
  logic [RankW-1:0]  m_rank;

  assign bv[ENTRIES]    = 1'b0;
  assign bcnt[ENTRIES]  = '0;
  assign brank[ENTRIES] = '0;
  assign bidx[ENTRIES]  = '0;
  assign fv[ENTRIES]    = 1'b0;
  assign fidx[ENTRIES]  = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lfu_cell #(.IdxW(IdxW), .RankW(RankW)) u_cell (
      .clk_i, .rst_ni,
      .key_i(key_q), .val_i(val_q), .my_idx_i(IdxW'(g)),
      .cmd_i(cmd), .put_i(op_q), .sel_idx_i(sel_idx), .sel_rank_i(sel_rank),
      .top_rank_i(RankW'(fill_q - 1'b1)), .new_rank_i(RankW'(fill_q)),
      .bv_i(bv[g+1]), .bcnt_i(bcnt[g+1]), .brank_i(brank[g+1]), .bidx_i(bidx[g+1]),
      .fv_i(fv[g+1]), .fidx_i(fidx[g+1]),
      .bv_o(bv[g]), .bcnt_o(bcnt[g]), .brank_o(brank[g]), .bidx_o(bidx[g]),
      .fv_o(fv[g]), .fidx_o(fidx[g]),
      .match_o(match[g]), .valid_o(valid[g]), .value_o(value[g]), .rank_o(rank[g])
    );
  end

  always_comb begin
    any_hit = |match;
    m_idx   = '0;
    m_val   = '0;
    m_rank  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i]) begin
        m_idx  = IdxW'(i);
        m_val  = value[i];
        m_rank = rank[i];
      end
    end
  end

  assign cap = (CapW'(limit_q) < CapW'(ENTRIES)) ? CapW'(limit_q) : CapW'(ENTRIES);
  assign need_evict = (CapW'(fill_q) >= cap) && !evicted_q;
  assign scan_last  = (scan_q == IdxW'(ENTRIES - 1));
  // lowest free slot once the evicted one is freed
  assign free_idx   = (fv_q && (fidx_q < eidx_q)) ? fidx_q : eidx_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (start_i) state_d = ST_SEARCH;
      ST_SEARCH: if (scan_last) state_d = ST_UPDATE;
      ST_UPDATE: begin
        if (op_q == OP_PUT && !hit_q && cap != '0 && need_evict) state_d = ST_UPDATE;
        else state_d = ST_DONE;
      end
      ST_DONE:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    sel_idx   = hidx_q;
    sel_rank  = hrank_q;
    fill_d    = fill_q;
    evicted_d = evicted_q;
    rd_d      = rd_q;
    scan_d    = '0;
    unique case (state_q)
      ST_SEARCH: begin
        scan_d    = scan_q + 1'b1;
        evicted_d = 1'b0;
        rd_d = (op_q == OP_PUT) ? '0 : (any_hit ? m_val : '1);
      end
      ST_UPDATE: begin
        if (hit_q) begin
          if (op_q == OP_GET || cap != '0) cmd.touch = 1'b1;
        end else if (op_q == OP_PUT && cap != '0) begin
          if (need_evict) begin
            cmd.evict = 1'b1;
            sel_idx   = eidx_q;
            sel_rank  = erank_q;
            fill_d    = fill_q - 1'b1;
            evicted_d = 1'b1;
          end else begin
            cmd.fill = 1'b1;
            sel_idx  = fidx_q;
            fill_d   = fill_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      limit_q   <= LimitW'(16);
      fill_q    <= '0;
      done_q    <= 1'b0;
      evicted_q <= 1'b0;
      scan_q    <= '0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      evicted_q <= evicted_d;
      scan_q    <= scan_d;
      done_q    <= (state_q == ST_DONE);
      if (entry_limit_we_i) limit_q <= entry_limit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= rd_d;
    if (state_q == ST_IDLE && start_i) begin
      op_q  <= opcode_i;
      key_q <= lookup_key_i;
      val_q <= store_value_i;
    end
    if (state_q == ST_SEARCH && scan_last) begin
      hit_q   <= any_hit;
      rhit_q  <= any_hit;
      hidx_q  <= m_idx;
      hrank_q <= m_rank;
      eidx_q  <= bidx[0];
      erank_q <= brank[0];
      fidx_q  <= fidx[0];
      fv_q    <= fv[0];
    end else if (cmd.evict) begin
      fidx_q  <= free_idx;
      fv_q    <= 1'b1;
    end
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign read_value_o = rd_q;
  assign hit_o        = rhit_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(ENTRIES)) else $error("fill above entries");
  a_fill_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> $countones(valid) == int'(fill_q))
    else $error("fill count mismatch");
  a_one_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match)) else $error("duplicate key");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("result held");
  a_evict_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE && cmd.evict) |-> bv[0]) else $error("evict of empty store");
`endif

endmodule
